[rtl/cst_pkg.sv]
package cst_pkg;

  // operation kinds
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_WAIT   = 2'd1;
  localparam logic [1:0] KIND_SIGNAL = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFREE   = 2'd1;
  localparam logic [1:0] ST_QFULL    = 2'd2;
  localparam logic [1:0] ST_NOTALLOC = 2'd3;

  // free-entry scan examines this many valid bits per cycle
  localparam int GRP_SIZE = 8;
  localparam int GRP_W    = 3;

  localparam int CNT_W = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pid;
    logic [3:0]  sem_index;
    logic [14:0] start_count;
  } cst_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         allocated_index;
    logic               caller_blocked;
    logic               wake_valid;
    logic [7:0]         wake_pid;
    logic signed [15:0] count_after;
  } cst_out_t;

  typedef struct packed {
    logic accept;
    logic out_load;
    logic scan;
    logic exec;
    logic wake;
  } cst_cmd_t;

  typedef struct packed {
    logic in_alloc;
    logic in_rw_ok;
    logic found;
    logic last;
    logic need_wake;
    logic out_free;
  } cst_stat_t;

endpackage

[rtl/cst_ram.sv]
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/cst_ctrl.sv]
module cst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cst_pkg::cst_stat_t  st,
  output cst_pkg::cst_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_WAKE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       take;
  logic       accept;

  // a result waiting in DONE moves out in the same cycle a new transaction comes in
  assign take   = (state_r == S_IDLE) || ((state_r == S_DONE) && st.out_free);
  assign accept = take && in_valid;
  assign in_stall = !take;

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.out_load = (state_r == S_DONE) && st.out_free;
    cmd.scan     = (state_r == S_SCAN);
    cmd.exec     = (state_r == S_READ);
    cmd.wake     = (state_r == S_WAKE);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE, S_DONE: begin
        if (accept) begin
          if (st.in_alloc) begin
            state_nxt = S_SCAN;
          end else if (st.in_rw_ok) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (state_r == S_DONE && st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (st.found || st.last) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        state_nxt = st.need_wake ? S_WAKE : S_DONE;
      end
      S_WAKE: begin
        state_nxt = S_DONE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_wake_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && st.need_wake) |=> cmd.wake)
    else $error("wake read not followed by wake cycle");

endmodule

[rtl/cst_dp.sv]
module cst_dp #(
  parameter int NUM_SEMS    = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_BITS    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cst_pkg::cst_in_t    in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output cst_pkg::cst_out_t   out_data,
  input  cst_pkg::cst_cmd_t   cmd,
  output cst_pkg::cst_stat_t  st
);

  localparam int SW   = $clog2(NUM_SEMS);
  localparam int QW   = $clog2(QUEUE_DEPTH);
  localparam int FW   = QW + 1;
  localparam int NGRP = (NUM_SEMS + cst_pkg::GRP_SIZE - 1) / cst_pkg::GRP_SIZE;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int NPAD = NGRP * cst_pkg::GRP_SIZE;
  localparam int TW   = cst_pkg::CNT_W + QW + QW + FW;
  localparam int WAW  = SW + QW;
  localparam int WDEP = NUM_SEMS * (1 << QW);

  cst_pkg::cst_in_t  item_r;
  cst_pkg::cst_out_t res_r;
  cst_pkg::cst_out_t res_nxt;
  cst_pkg::cst_out_t quick;
  cst_pkg::cst_out_t out_data_r;
  logic              out_valid_r;
  logic [NUM_SEMS-1:0] valid_r;
  logic [GW-1:0]     grp_r;

  // per-entry table: count, head, tail, fill
  logic              tbl_we;
  logic [SW-1:0]     tbl_waddr;
  logic [TW-1:0]     tbl_wdata;
  logic              tbl_re;
  logic [SW-1:0]     tbl_raddr;
  logic [TW-1:0]     tbl_rdata;

  logic              wr_we;
  logic [WAW-1:0]    wr_waddr;
  logic [PID_BITS-1:0] wr_wdata;
  logic              wr_re;
  logic [WAW-1:0]    wr_raddr;
  logic [PID_BITS-1:0] wr_rdata;

  logic [SW-1:0]     in_idx;
  logic              in_rw;
  logic              in_range;
  logic [SW-1:0]     it_idx;

  logic [NPAD-1:0]   vpad;
  logic [cst_pkg::GRP_SIZE-1:0] slice;
  logic [cst_pkg::GRP_W-1:0]    pe;
  logic [SW-1:0]     scan_idx;
  logic              found;
  logic              last;
  logic              need_wake;

  logic signed [15:0] c;
  logic signed [15:0] n;
  logic [QW-1:0]     head;
  logic [QW-1:0]     tail;
  logic [FW-1:0]     fill;
  logic [QW-1:0]     head_inc;
  logic [QW-1:0]     tail_inc;

  // input decode
  assign in_idx   = SW'(in_data.sem_index);
  assign in_range = (32'(in_data.sem_index) < NUM_SEMS);
  assign in_rw    = (in_data.kind == cst_pkg::KIND_WAIT) ||
                    (in_data.kind == cst_pkg::KIND_SIGNAL);

  always_comb begin
    quick = '0;
    if (in_rw && !(in_range && valid_r[in_idx])) begin
      quick.status = cst_pkg::ST_NOTALLOC;
    end
  end

  assign tbl_re    = cmd.accept && in_rw && in_range && valid_r[in_idx];
  assign tbl_raddr = in_idx;

  // free-entry scan, one group of valid bits per cycle
  always_comb begin
    vpad = '1;
    vpad[NUM_SEMS-1:0] = valid_r;
  end

  assign slice = vpad[grp_r * cst_pkg::GRP_SIZE +: cst_pkg::GRP_SIZE];

  always_comb begin
    pe = '0;
    for (int i = cst_pkg::GRP_SIZE - 1; i >= 0; i--) begin
      if (!slice[i]) begin
        pe = cst_pkg::GRP_W'(i);
      end
    end
  end

  assign found    = !(&slice);
  assign last     = (grp_r == GW'(NGRP - 1));
  assign scan_idx = SW'({grp_r, pe});

  // unpack the entry read at accept
  assign it_idx = SW'(item_r.sem_index);
  assign {c, head, tail, fill} = tbl_rdata;
  assign head_inc = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;

  always_comb begin
    res_nxt   = res_r;
    tbl_we    = 1'b0;
    tbl_waddr = it_idx;
    tbl_wdata = tbl_rdata;
    wr_we     = 1'b0;
    wr_waddr  = {it_idx, tail};
    wr_wdata  = PID_BITS'(item_r.pid);
    wr_re     = 1'b0;
    wr_raddr  = {it_idx, head};
    need_wake = 1'b0;
    n         = c;

    if (cmd.scan) begin
      if (found) begin
        tbl_we    = 1'b1;
        tbl_waddr = scan_idx;
        tbl_wdata = {signed'({1'b0, item_r.start_count}), {QW{1'b0}}, {QW{1'b0}},
                     {FW{1'b0}}};
        res_nxt = '0;
        res_nxt.status          = cst_pkg::ST_OK;
        res_nxt.allocated_index = 4'(scan_idx);
        res_nxt.count_after     = signed'({1'b0, item_r.start_count});
      end else if (last) begin
        res_nxt = '0;
        res_nxt.status = cst_pkg::ST_NOFREE;
      end
    end

    if (cmd.exec) begin
      res_nxt = '0;
      if (item_r.kind == cst_pkg::KIND_WAIT) begin
        // hold at the minimum count
        n = (c == 16'sh8000) ? c : c - 16'sd1;
        if (n[15]) begin
          if (fill >= FW'(QUEUE_DEPTH)) begin
            res_nxt.status      = cst_pkg::ST_QFULL;
            res_nxt.count_after = c;
          end else begin
            wr_we     = 1'b1;
            tbl_we    = 1'b1;
            tbl_wdata = {n, head, tail_inc, fill + 1'b1};
            res_nxt.caller_blocked = 1'b1;
            res_nxt.count_after    = n;
          end
        end else begin
          tbl_we    = 1'b1;
          tbl_wdata = {n, head, tail, fill};
          res_nxt.count_after = n;
        end
      end else begin
        // saturate at the maximum count
        n = (c == 16'sh7FFF) ? c : c + 16'sd1;
        tbl_we = 1'b1;
        res_nxt.count_after = n;
        if ((n[15] || n == 16'sd0) && fill != '0) begin
          need_wake = 1'b1;
          wr_re     = 1'b1;
          tbl_wdata = {n, head_inc, tail, fill - 1'b1};
          res_nxt.wake_valid = 1'b1;
        end else begin
          tbl_wdata = {n, head, tail, fill};
        end
      end
    end

    if (cmd.wake) begin
      res_nxt.wake_pid = 8'(wr_rdata);
    end
  end

  cst_ram #(
    .WIDTH (TW),
    .DEPTH (NUM_SEMS)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  cst_ram #(
    .WIDTH (PID_BITS),
    .DEPTH (WDEP)
  ) u_wait (
    .clk   (clk),
    .we    (wr_we),
    .waddr (wr_waddr),
    .wdata (wr_wdata),
    .re    (wr_re),
    .raddr (wr_raddr),
    .rdata (wr_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
      grp_r  <= '0;
      res_r  <= quick;
    end else begin
      res_r <= res_nxt;
      if (cmd.scan && !found && !last) begin
        grp_r <= grp_r + 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.scan && found) begin
        valid_r[scan_idx] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    st           = '0;
    st.in_alloc  = (in_data.kind == cst_pkg::KIND_ALLOC);
    st.in_rw_ok  = tbl_re;
    st.found     = found;
    st.last      = last;
    st.need_wake = need_wake;
    st.out_free  = !out_valid_r || !out_stall;
  end

  a_wait_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_we && wr_re))
    else $error("wait store written and read in one cycle");

  a_alloc_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && found) |=> valid_r[$past(scan_idx)])
    else $error("allocated entry not marked valid");

  a_blocked_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.caller_blocked) |->
      (out_data_r.status == cst_pkg::ST_OK && !out_data_r.wake_valid))
    else $error("blocked caller with bad status or wake");

endmodule

[rtl/counting_semaphore_table_top.sv]
// Table of NUM_SEMS counting semaphores, each with a FIFO of up to QUEUE_DEPTH
// blocked process IDs. Each input transaction (allocate, wait, signal) yields
// exactly one result transaction. A wait or a signal that wakes nobody reads
// the per-entry table at accept, then does its read-modify-write; a signal
// that wakes a process adds a read of the wait store. An allocate scans the
// entry valid bits eight per cycle and stops at the first group holding a free
// entry or at the last group; an op on an unallocated entry or an unknown kind
// goes straight to the result. One transaction is in work at a time; a finished
// result sits in an output register, so the next input is taken while it waits.
// Entry counts and queues live in RAM and need no clearing after reset.
module counting_semaphore_table_top #(
  parameter int NUM_SEMS    = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_BITS    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cst_pkg::cst_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cst_pkg::cst_out_t  out_data
);

  cst_pkg::cst_cmd_t  cmd;
  cst_pkg::cst_stat_t st;

  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  cst_dp #(
    .NUM_SEMS    (NUM_SEMS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_BITS    (PID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

[test/tb.sv]
module tb;

  localparam int NUM_SEMS    = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int PID_BITS    = 8;
  localparam int RANDOM_OPS  = 580;
  localparam int IN_W        = $bits(cst_pkg::cst_in_t);

  typedef struct {
    logic [1:0]        kind;
    logic [7:0]        pid;
    logic [3:0]        sem;
    logic [14:0]       start;
    int                reps;
    bit                typed;
    cst_pkg::cst_out_t result;
  } op_row_t;

  localparam cst_pkg::cst_out_t NOTALLOC_RESULT =
    '{cst_pkg::ST_NOTALLOC, 4'd0, 1'b0, 1'b0, 8'd0, 16'sd0};
  localparam cst_pkg::cst_out_t ZERO_RESULT =
    '{cst_pkg::ST_OK, 4'd0, 1'b0, 1'b0, 8'd0, 16'sd0};

  // pid and start_count advance by one on each repeat of a row
  op_row_t directed_ops [17] = '{
    '{cst_pkg::KIND_SIGNAL, 8'h5A, 4'd5, 15'd0,      1,  1'b1, NOTALLOC_RESULT},
    '{cst_pkg::KIND_WAIT,   8'hFF, 4'd0, 15'h7FFF,   1,  1'b1, NOTALLOC_RESULT},
    '{cst_pkg::KIND_NOP,    8'hFF, 4'hF, 15'h7FFF,   1,  1'b1, ZERO_RESULT},
    '{cst_pkg::KIND_ALLOC,  8'h00, 4'hF, 15'h7FFF,   1,  1'b1,
      '{cst_pkg::ST_OK, 4'd0, 1'b0, 1'b0, 8'd0, 16'sd32767}},
    // count already at its top: signal saturates
    '{cst_pkg::KIND_SIGNAL, 8'h00, 4'd0, 15'd0,      1,  1'b1,
      '{cst_pkg::ST_OK, 4'd0, 1'b0, 1'b0, 8'd0, 16'sd32767}},
    '{cst_pkg::KIND_WAIT,   8'h01, 4'd0, 15'd0,      1,  1'b1,
      '{cst_pkg::ST_OK, 4'd0, 1'b0, 1'b0, 8'd0, 16'sd32766}},
    '{cst_pkg::KIND_ALLOC,  8'h00, 4'd0, 15'd0,      1,  1'b1,
      '{cst_pkg::ST_OK, 4'd1, 1'b0, 1'b0, 8'd0, 16'sd0}},
    // signal with nobody queued
    '{cst_pkg::KIND_SIGNAL, 8'h00, 4'd1, 15'd0,      1,  1'b1,
      '{cst_pkg::ST_OK, 4'd0, 1'b0, 1'b0, 8'd0, 16'sd1}},
    '{cst_pkg::KIND_WAIT,   8'hFF, 4'd1, 15'd0,      1,  1'b1, ZERO_RESULT},
    '{cst_pkg::KIND_WAIT,   8'h80, 4'd1, 15'd0,      16, 1'b0, ZERO_RESULT},
    // queue holds QUEUE_DEPTH ids: wait is refused, count unchanged
    '{cst_pkg::KIND_WAIT,   8'h00, 4'd1, 15'd0,      1,  1'b1,
      '{cst_pkg::ST_QFULL, 4'd0, 1'b0, 1'b0, 8'd0, -16'sd16}},
    '{cst_pkg::KIND_SIGNAL, 8'h00, 4'd1, 15'd0,      2,  1'b0, ZERO_RESULT},
    '{cst_pkg::KIND_WAIT,   8'h00, 4'd1, 15'd0,      1,  1'b0, ZERO_RESULT},
    '{cst_pkg::KIND_SIGNAL, 8'h00, 4'd1, 15'd0,      15, 1'b0, ZERO_RESULT},
    '{cst_pkg::KIND_ALLOC,  8'h00, 4'd0, 15'd3,      14, 1'b0, ZERO_RESULT},
    // every entry taken
    '{cst_pkg::KIND_ALLOC,  8'hFF, 4'hF, 15'h7FFF,   1,  1'b1,
      '{cst_pkg::ST_NOFREE, 4'd0, 1'b0, 1'b0, 8'd0, 16'sd0}},
    '{cst_pkg::KIND_WAIT,   8'h00, 4'hF, 15'd0,      1,  1'b0, ZERO_RESULT}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  cst_pkg::cst_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  cst_pkg::cst_out_t out_data;

  // predictor copy of the semaphore table
  bit          sem_used [NUM_SEMS];
  int          sem_count [NUM_SEMS];
  logic [7:0]  waiters [NUM_SEMS][QUEUE_DEPTH];
  int unsigned q_head [NUM_SEMS];
  int unsigned q_tail [NUM_SEMS];
  int unsigned q_fill [NUM_SEMS];

  cst_pkg::cst_out_t pending_results [$];
  int                mismatches = 0;
  int                in_quiet = 0;
  int                out_quiet = 0;

  counting_semaphore_table_top #(
    .NUM_SEMS   (NUM_SEMS),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PID_BITS   (PID_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic cst_pkg::cst_out_t semaphore_op(input cst_pkg::cst_in_t op);
    cst_pkg::cst_out_t r;
    int                c;
    int                n;
    bit                found;
    int unsigned       s;
    r = '0;
    s = op.sem_index;
    found = 1'b0;
    case (op.kind)
      cst_pkg::KIND_ALLOC: begin
        r.status = cst_pkg::ST_NOFREE;
        for (int e = 0; e < NUM_SEMS; e++) begin
          if (!found && !sem_used[e]) begin
            found = 1'b1;
            sem_used[e] = 1'b1;
            sem_count[e] = int'(op.start_count);
            q_head[e] = 0;
            q_tail[e] = 0;
            q_fill[e] = 0;
            r.status = cst_pkg::ST_OK;
            r.allocated_index = 4'(e);
            r.count_after = 16'(op.start_count);
          end
        end
      end
      cst_pkg::KIND_WAIT: begin
        if (s >= NUM_SEMS || !sem_used[s]) begin
          r.status = cst_pkg::ST_NOTALLOC;
        end else begin
          c = sem_count[s];
          n = (c > -32768) ? c - 1 : c;
          if (n < 0 && q_fill[s] >= QUEUE_DEPTH) begin
            r.status = cst_pkg::ST_QFULL;
            r.count_after = 16'(c);
          end else begin
            if (n < 0) begin
              waiters[s][q_tail[s]] = op.pid & 8'((1 << PID_BITS) - 1);
              q_tail[s] = (q_tail[s] + 1) % QUEUE_DEPTH;
              q_fill[s]++;
              r.caller_blocked = 1'b1;
            end
            sem_count[s] = n;
            r.count_after = 16'(n);
          end
        end
      end
      cst_pkg::KIND_SIGNAL: begin
        if (s >= NUM_SEMS || !sem_used[s]) begin
          r.status = cst_pkg::ST_NOTALLOC;
        end else begin
          c = sem_count[s];
          n = (c < 32767) ? c + 1 : c;
          sem_count[s] = n;
          if (n <= 0 && q_fill[s] > 0) begin
            r.wake_valid = 1'b1;
            r.wake_pid = waiters[s][q_head[s]];
            q_head[s] = (q_head[s] + 1) % QUEUE_DEPTH;
            q_fill[s]--;
          end
          r.count_after = 16'(n);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly short idles, a few long ones, and now and then a quiet stretch
  function automatic int idle_len(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_op(input cst_pkg::cst_in_t op, input bit typed,
                         input cst_pkg::cst_out_t given);
    int                gap;
    cst_pkg::cst_out_t predicted;
    gap = idle_len(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
    predicted = semaphore_op(op);
    pending_results.push_back(typed ? given : predicted);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cst_pkg::cst_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending: %h", out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("allocated_index", want.allocated_index, out_data.allocated_index);
        check_field("caller_blocked", want.caller_blocked, out_data.caller_blocked);
        check_field("wake_valid", want.wake_valid, out_data.wake_valid);
        check_field("wake_pid", want.wake_pid, out_data.wake_pid);
        check_field("count_after", $signed(want.count_after), $signed(out_data.count_after));
      end
    end
  end

  initial begin
    int len;
    @(posedge clk);
    forever begin
      len = idle_len(out_quiet);
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  initial begin
    cst_pkg::cst_in_t op;
    int               issued;
    int               nwaits;
    int               nsigs;
    int               sem;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_ops[i]) begin
      for (int k = 0; k < directed_ops[i].reps; k++) begin
        op.kind        = directed_ops[i].kind;
        op.pid         = directed_ops[i].pid + 8'(k);
        op.sem_index   = directed_ops[i].sem;
        op.start_count = directed_ops[i].start + 15'(k);
        send_op(op, directed_ops[i].typed, directed_ops[i].result);
      end
    end

    // random part: wait bursts followed by signals on one entry, plus noise
    issued = 0;
    while (issued < RANDOM_OPS) begin
      if ($urandom_range(0, 3) != 0) begin
        sem = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 2) : $urandom_range(0, 15);
        nwaits = $urandom_range(1, 24);
        nsigs  = $urandom_range(nwaits / 2, nwaits + 3);
        for (int k = 0; k < nwaits + nsigs; k++) begin
          op.kind        = (k < nwaits) ? cst_pkg::KIND_WAIT : cst_pkg::KIND_SIGNAL;
          op.pid         = 8'($urandom);
          op.sem_index   = 4'(sem);
          op.start_count = 15'($urandom);
          send_op(op, 1'b0, ZERO_RESULT);
          issued++;
        end
      end else begin
        op = cst_pkg::cst_in_t'(IN_W'($urandom));
        send_op(op, 1'b0, ZERO_RESULT);
        if (op.kind != cst_pkg::KIND_NOP) issued++;
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cst_pkg.sv
rtl/cst_ram.sv
rtl/cst_ctrl.sv
rtl/cst_dp.sv
rtl/counting_semaphore_table_top.sv
test/tb.sv
